/* sv/ple_pkg.sv */
// Shared types, constants and helpers for the positional list engine.
// No dependencies; every other file takes names from here by scope.
`default_nettype none

package ple_pkg;

  // Store geometry
  localparam int CAPACITY  = 64;
  localparam int ELEM_W    = 32;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 7;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  // Result field widths
  localparam int STATUS_W  = 2;
  localparam int FIDX_W    = 6;
  localparam int COUNT_W   = 7;
  localparam int OPCODE_W  = 3;

  // Stream widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_BITS   = OPCODE_W + POS_W + VAL_W;
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = STATUS_W + VAL_W + FIDX_W + COUNT_W + 2;
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

  // Search / read tree: cells are taken in groups of eight
  localparam int GRP_SIZE  = 8;
  localparam int GRP_SEL_W = $clog2(GRP_SIZE);
  localparam int NGROUPS   = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_W     = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int PAD_CELLS = NGROUPS * GRP_SIZE;

  typedef logic [ELEM_W-1:0] elem_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_INSERT   = 3'd0,
    OP_ERASE    = 3'd1,
    OP_RETRIEVE = 3'd2,
    OP_REPLACE  = 3'd3,
    OP_FIND     = 3'd4,
    OP_CLEAR    = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // What each cell does at the commit edge
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_INS   = 2'd1,
    CELL_ERA   = 2'd2,
    CELL_WR    = 2'd3
  } cell_op_t;

  // Control broadcast along the chain
  typedef struct packed {
    cell_op_t           kind;
    logic [POS_W-1:0]   pos;
    logic [CNT_W-1:0]   count;
    elem_t              val;
  } cell_ctrl_t;

  // Input value to stored element (sign-extend or truncate)
  function automatic elem_t to_elem(input logic signed [VAL_W-1:0] v);
    return elem_t'(v);
  endfunction

  // Stored element to output value (sign-extend from element width)
  function automatic logic [VAL_W-1:0] from_elem(input elem_t e);
    logic signed [ELEM_W-1:0] s;
    s = $signed(e);
    return VAL_W'(s);
  endfunction

endpackage

`default_nettype wire

/* sv/ple_cell.sv */
// One list entry of the cell chain: shifts, loads and compares its word.
// Depends on ple_pkg.
`default_nettype none

module ple_cell (
  input  wire logic                    clk,
  input  wire logic [ple_pkg::IDX_W-1:0] idx,
  input  wire ple_pkg::cell_ctrl_t     ctrl,
  input  wire ple_pkg::elem_t          left_q,
  input  wire ple_pkg::elem_t          right_q,
  output ple_pkg::elem_t               q,
  output logic                         match
);

  ple_pkg::elem_t q_r, q_nxt;
  logic [ple_pkg::POS_W-1:0] my_pos;

  assign my_pos = ple_pkg::POS_W'(idx);

  // Next word: neighbour on a shift, new value on a write
  always_comb begin
    q_nxt = q_r;
    case (ctrl.kind)
      ple_pkg::CELL_INS: begin
        if (my_pos > ctrl.pos) q_nxt = left_q;
        else if (my_pos == ctrl.pos) q_nxt = ctrl.val;
      end
      ple_pkg::CELL_ERA: begin
        if (my_pos >= ctrl.pos) q_nxt = right_q;
      end
      ple_pkg::CELL_WR: begin
        if (my_pos == ctrl.pos) q_nxt = ctrl.val;
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q     = q_r;
  // Only occupied cells take part in a search
  assign match = (q_r == ctrl.val) && (ple_pkg::CNT_W'(idx) < ctrl.count);

endmodule

`default_nettype wire

/* sv/ple_group.sv */
// Registered first level of the read/search tree over eight cells.
// Depends on ple_pkg.
`default_nettype none

module ple_group (
  input  wire logic                           clk,
  input  wire logic                           load,
  input  wire ple_pkg::elem_t                 words [ple_pkg::GRP_SIZE],
  input  wire logic [ple_pkg::GRP_SIZE-1:0]   hits,
  input  wire logic [ple_pkg::GRP_SEL_W-1:0]  sel,
  output ple_pkg::elem_t                      word_r,
  output logic                                any_r,
  output logic [ple_pkg::GRP_SEL_W-1:0]       first_r
);

  logic [ple_pkg::GRP_SEL_W-1:0] first_nxt;

  // Lowest matching cell within the group
  always_comb begin
    first_nxt = '0;
    for (int k = ple_pkg::GRP_SIZE - 1; k >= 0; k--) begin
      if (hits[k]) first_nxt = ple_pkg::GRP_SEL_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r  <= words[sel];
      any_r   <= |hits;
      first_r <= first_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/positional_list_engine_top.sv */
// Top level of the positional list engine: request control, cell chain,
// search/read tree and result register. Depends on ple_pkg, ple_cell and
// ple_group.
//
// Usage:
//   Requests arrive on in_t* (opcode, position, value) and each gives one
//   result on out_t* (status, data_out, found_index, entry_count, is_full,
//   is_empty). The list lives in a chain of 64 cells, one word each;
//   insert and erase shift every cell after the position by one place in
//   the commit edge, replace loads one cell, and find compares all cells at
//   once.
//   Sequence: the request is captured on acceptance, the compare state loads
//   the registered first level of the read/search tree over groups of eight
//   cells, and the done state loads the result register once the receiver
//   can take it. One request is in flight at a time.
//   The result register frees the input side: a new request is taken while
//   the previous result still waits. If the receiver stalls, the next
//   request is held at its final stage and the list is not changed until
//   its result can be loaded.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   result; stored words are not cleared and are never read while empty.
`default_nettype none

module positional_list_engine_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // opcode[2:0], position[9:3], value[41:10], zero pad [47:42]
  input  wire logic [ple_pkg::IN_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // status[1:0], data_out[33:2], found_index[39:34], entry_count[46:40],
  // is_full[47], is_empty[48], zero pad [55:49]
  output logic [ple_pkg::OUT_W-1:0]       out_tdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Request held for the whole operation
  logic [ple_pkg::OPCODE_W-1:0] op_r;
  logic [ple_pkg::POS_W-1:0]    pos_r;
  ple_pkg::elem_t               val_r;
  logic [ple_pkg::CNT_W-1:0]    count_r, count_nxt;

  logic                         out_valid_r;
  logic [ple_pkg::OUT_W-1:0]    out_data_r;
  logic                         out_load;
  logic                         accept;

  ple_pkg::cell_ctrl_t          ctrl;
  ple_pkg::cell_op_t            kind;

  ple_pkg::elem_t               cell_q   [ple_pkg::CAPACITY];
  logic [ple_pkg::CAPACITY-1:0] cell_hit;
  ple_pkg::elem_t               pad_q    [ple_pkg::PAD_CELLS];
  logic [ple_pkg::PAD_CELLS-1:0] pad_hit;

  ple_pkg::elem_t               grp_word  [ple_pkg::NGROUPS];
  logic [ple_pkg::NGROUPS-1:0]  grp_any;
  logic [ple_pkg::GRP_SEL_W-1:0] grp_first [ple_pkg::NGROUPS];

  ple_pkg::status_t             status;
  logic [ple_pkg::VAL_W-1:0]    data;
  logic [ple_pkg::FIDX_W-1:0]   fidx;
  logic [ple_pkg::GRP_W-1:0]    gsel;
  logic                         ghit;
  ple_pkg::elem_t               rd_word;
  logic                         full_nxt, empty_nxt;

  // Handshake
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_CMP;
      S_CMP:  state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_tdata[ple_pkg::OPCODE_W-1:0];
      pos_r <= in_tdata[ple_pkg::OPCODE_W +: ple_pkg::POS_W];
      val_r <= ple_pkg::to_elem(in_tdata[ple_pkg::OPCODE_W + ple_pkg::POS_W +: ple_pkg::VAL_W]);
    end
  end

  // Cell chain
  assign ctrl.kind  = out_load ? kind : ple_pkg::CELL_HOLD;
  assign ctrl.pos   = pos_r;
  assign ctrl.count = count_r;
  assign ctrl.val   = val_r;

  for (genvar i = 0; i < ple_pkg::CAPACITY; i++) begin : g_cell
    ple_cell u_cell (
      .clk     (clk),
      .idx     (ple_pkg::IDX_W'(i)),
      .ctrl    (ctrl),
      .left_q  (cell_q[(i == 0) ? 0 : i - 1]),
      .right_q (cell_q[(i == ple_pkg::CAPACITY - 1) ? i : i + 1]),
      .q       (cell_q[i]),
      .match   (cell_hit[i])
    );
  end

  // Pad the chain to whole groups
  for (genvar i = 0; i < ple_pkg::PAD_CELLS; i++) begin : g_pad
    if (i < ple_pkg::CAPACITY) begin : g_real
      assign pad_q[i]   = cell_q[i];
      assign pad_hit[i] = cell_hit[i];
    end else begin : g_fill
      assign pad_q[i]   = '0;
      assign pad_hit[i] = 1'b0;
    end
  end

  // First tree level, loaded in the compare state
  for (genvar g = 0; g < ple_pkg::NGROUPS; g++) begin : g_grp
    ple_pkg::elem_t words [ple_pkg::GRP_SIZE];
    for (genvar k = 0; k < ple_pkg::GRP_SIZE; k++) begin : g_w
      assign words[k] = pad_q[g * ple_pkg::GRP_SIZE + k];
    end
    ple_group u_group (
      .clk     (clk),
      .load    (state_r == S_CMP),
      .words   (words),
      .hits    (pad_hit[g * ple_pkg::GRP_SIZE +: ple_pkg::GRP_SIZE]),
      .sel     (pos_r[ple_pkg::GRP_SEL_W-1:0]),
      .word_r  (grp_word[g]),
      .any_r   (grp_any[g]),
      .first_r (grp_first[g])
    );
  end

  // Second tree level: pick group for read and for first match
  assign rd_word = grp_word[pos_r[ple_pkg::GRP_SEL_W +: ple_pkg::GRP_W]];

  always_comb begin
    gsel = '0;
    ghit = 1'b0;
    for (int g = ple_pkg::NGROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        gsel = ple_pkg::GRP_W'(g);
        ghit = 1'b1;
      end
    end
  end

  // Operation decode and result
  always_comb begin
    status    = ple_pkg::ST_OK;
    data      = '0;
    fidx      = '0;
    count_nxt = count_r;
    kind      = ple_pkg::CELL_HOLD;
    unique case (op_r)
      ple_pkg::OP_INSERT: begin
        if (ple_pkg::CNT_W'(pos_r) > count_r || pos_r > ple_pkg::POS_W'(ple_pkg::CAPACITY))
          status = ple_pkg::ST_RANGE;
        else if (count_r >= ple_pkg::CNT_W'(ple_pkg::CAPACITY))
          status = ple_pkg::ST_FULL;
        else begin
          kind      = ple_pkg::CELL_INS;
          count_nxt = count_r + 1'b1;
        end
      end
      ple_pkg::OP_ERASE: begin
        if (pos_r >= ple_pkg::POS_W'(count_r))
          status = ple_pkg::ST_RANGE;
        else begin
          data      = ple_pkg::from_elem(rd_word);
          kind      = ple_pkg::CELL_ERA;
          count_nxt = count_r - 1'b1;
        end
      end
      ple_pkg::OP_RETRIEVE: begin
        if (pos_r >= ple_pkg::POS_W'(count_r)) status = ple_pkg::ST_RANGE;
        else data = ple_pkg::from_elem(rd_word);
      end
      ple_pkg::OP_REPLACE: begin
        if (pos_r >= ple_pkg::POS_W'(count_r)) status = ple_pkg::ST_RANGE;
        else kind = ple_pkg::CELL_WR;
      end
      ple_pkg::OP_FIND: begin
        if (ghit) fidx = ple_pkg::FIDX_W'({gsel, grp_first[gsel]});
        else status = ple_pkg::ST_MISSING;
      end
      ple_pkg::OP_CLEAR: count_nxt = '0;
      default: status = ple_pkg::ST_OK;
    endcase
  end

  assign full_nxt  = (count_nxt == ple_pkg::CNT_W'(ple_pkg::CAPACITY));
  assign empty_nxt = (count_nxt == '0);

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= ple_pkg::OUT_W'({empty_nxt, full_nxt, ple_pkg::COUNT_W'(count_nxt),
                                     fidx, data, status});
    end
  end

endmodule

`default_nettype wire
